// ===== src/utf8dec_pkg.sv =====
package utf8dec_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned CNT_W = 3;

  localparam logic [CP_W-1:0] MIN_CP_2  = 21'h00_0080;
  localparam logic [CP_W-1:0] MIN_CP_3  = 21'h00_0800;
  localparam logic [CP_W-1:0] MIN_CP_4  = 21'h01_0000;
  localparam logic [CP_W-1:0] MAX_CP    = 21'h10_FFFF;
  localparam logic [CP_W-1:0] SURR_LO   = 21'h00_D800;
  localparam logic [CP_W-1:0] SURR_HI   = 21'h00_DFFF;

  localparam logic [CNT_W-1:0] LEN_NONE = 3'd0;
  localparam logic [CNT_W-1:0] LEN_1    = 3'd1;
  localparam logic [CNT_W-1:0] LEN_2    = 3'd2;
  localparam logic [CNT_W-1:0] LEN_3    = 3'd3;
  localparam logic [CNT_W-1:0] LEN_4    = 3'd4;

  typedef enum logic [2:0] {
    BC_ASCII,
    BC_CONT,
    BC_LEAD2,
    BC_LEAD3,
    BC_LEAD4,
    BC_BAD
  } byte_class_t;

  // One command per accepted byte that yields results: err_count errors,
  // then optionally one tail result.
  typedef struct packed {
    logic [CNT_W-1:0] err_count;
    logic             has_tail;
    logic [CP_W-1:0]  tail_cp;
    logic [CNT_W-1:0] tail_count;
    logic             tail_bad;
    logic             eos;
  } cmd_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    if (b[7] == 1'b0)             c = BC_ASCII;
    else if (b[7:6] == 2'b10)     c = BC_CONT;
    else if (b[7:5] == 3'b110)    c = BC_LEAD2;
    else if (b[7:4] == 4'b1110)   c = BC_LEAD3;
    else if (b[7:3] == 5'b11110)  c = BC_LEAD4;
    else                          c = BC_BAD;
    return c;
  endfunction

  function automatic logic value_ok(input logic [CP_W-1:0] v, input logic [CNT_W-1:0] len);
    logic ok;
    ok = 1'b1;
    if (len == LEN_2 && v < MIN_CP_2) ok = 1'b0;
    if (len == LEN_3 && v < MIN_CP_3) ok = 1'b0;
    if (len == LEN_4 && v < MIN_CP_4) ok = 1'b0;
    if (v > MAX_CP) ok = 1'b0;
    if (v >= SURR_LO && v <= SURR_HI) ok = 1'b0;
    return ok;
  endfunction

endpackage

// ===== src/utf8dec_byte_if.sv =====
interface utf8dec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

// ===== src/utf8dec_char_if.sv =====
interface utf8dec_char_if;
  logic                          valid;
  logic                          ready;
  logic [utf8dec_pkg::CP_W-1:0]  code_point;
  logic [utf8dec_pkg::CNT_W-1:0] byte_count;
  logic                          bad_sequence;
  logic                          final_result;

  modport source (output valid, output code_point, output byte_count,
                  output bad_sequence, output final_result, input ready);
  modport sink   (input valid, input code_point, input byte_count,
                  input bad_sequence, input final_result, output ready);
endinterface

// ===== src/utf8dec_front.sv =====
module utf8dec_front (
  input  logic                  clk,
  input  logic                  rst,
  utf8dec_byte_if.sink          byte_stream,
  input  logic                  queue_ready,
  output logic                  push,
  output utf8dec_pkg::cmd_t     push_cmd
);

  logic [utf8dec_pkg::CP_W-1:0]  partial_value, partial_value_next;
  logic [utf8dec_pkg::CNT_W-1:0] expected_length, expected_length_next;
  logic [utf8dec_pkg::CNT_W-1:0] gathered_bytes, gathered_bytes_next;

  utf8dec_pkg::byte_class_t      cls;
  utf8dec_pkg::cmd_t             cmd;
  logic                          consumed;
  logic                          accept;
  logic [utf8dec_pkg::CP_W-1:0]  acc;
  logic [utf8dec_pkg::CNT_W-1:0] g_inc;

  assign byte_stream.ready = queue_ready;
  assign accept = byte_stream.valid && queue_ready;

  always_comb begin
    partial_value_next   = partial_value;
    expected_length_next = expected_length;
    gathered_bytes_next  = gathered_bytes;
    cmd                  = '0;
    cmd.eos              = byte_stream.end_of_string;
    cmd.tail_count       = utf8dec_pkg::LEN_1;
    consumed             = 1'b0;
    cls                  = utf8dec_pkg::classify(byte_stream.data_byte);
    acc = {partial_value[utf8dec_pkg::CP_W-7:0], byte_stream.data_byte[5:0]};
    g_inc = gathered_bytes + 3'd1;

    if (expected_length != utf8dec_pkg::LEN_NONE) begin
      if (cls == utf8dec_pkg::BC_CONT) begin
        consumed = 1'b1;
        if (g_inc >= expected_length) begin
          if (utf8dec_pkg::value_ok(acc, expected_length)) begin
            cmd.has_tail   = 1'b1;
            cmd.tail_cp    = acc;
            cmd.tail_count = expected_length;
          end else begin
            cmd.err_count = g_inc;
          end
          partial_value_next   = '0;
          expected_length_next = utf8dec_pkg::LEN_NONE;
          gathered_bytes_next  = '0;
        end else if (byte_stream.end_of_string) begin
          // truncated at end of string
          cmd.err_count        = g_inc;
          partial_value_next   = '0;
          expected_length_next = utf8dec_pkg::LEN_NONE;
          gathered_bytes_next  = '0;
        end else begin
          partial_value_next  = acc;
          gathered_bytes_next = g_inc;
        end
      end else begin
        // broken sequence: one error per gathered byte, byte re-read as lead
        cmd.err_count        = gathered_bytes;
        partial_value_next   = '0;
        expected_length_next = utf8dec_pkg::LEN_NONE;
        gathered_bytes_next  = '0;
      end
    end

    if (!consumed) begin
      unique case (cls)
        utf8dec_pkg::BC_ASCII: begin
          cmd.has_tail = 1'b1;
          cmd.tail_cp  = {{(utf8dec_pkg::CP_W-8){1'b0}}, byte_stream.data_byte};
        end
        utf8dec_pkg::BC_LEAD2: begin
          expected_length_next = utf8dec_pkg::LEN_2;
          partial_value_next   = {{(utf8dec_pkg::CP_W-5){1'b0}}, byte_stream.data_byte[4:0]};
          gathered_bytes_next  = utf8dec_pkg::LEN_1;
        end
        utf8dec_pkg::BC_LEAD3: begin
          expected_length_next = utf8dec_pkg::LEN_3;
          partial_value_next   = {{(utf8dec_pkg::CP_W-4){1'b0}}, byte_stream.data_byte[3:0]};
          gathered_bytes_next  = utf8dec_pkg::LEN_1;
        end
        utf8dec_pkg::BC_LEAD4: begin
          expected_length_next = utf8dec_pkg::LEN_4;
          partial_value_next   = {{(utf8dec_pkg::CP_W-3){1'b0}}, byte_stream.data_byte[2:0]};
          gathered_bytes_next  = utf8dec_pkg::LEN_1;
        end
        utf8dec_pkg::BC_CONT, utf8dec_pkg::BC_BAD: begin
          cmd.has_tail = 1'b1;
          cmd.tail_bad = 1'b1;
        end
        default: begin
          cmd.has_tail = 1'b1;
          cmd.tail_bad = 1'b1;
        end
      endcase
      // new lead cut off by end of string: one more error
      if (byte_stream.end_of_string && expected_length_next != utf8dec_pkg::LEN_NONE) begin
        cmd.err_count        = cmd.err_count + 3'd1;
        partial_value_next   = '0;
        expected_length_next = utf8dec_pkg::LEN_NONE;
        gathered_bytes_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      expected_length <= utf8dec_pkg::LEN_NONE;
      gathered_bytes  <= '0;
    end else if (accept) begin
      partial_value   <= partial_value_next;
      expected_length <= expected_length_next;
      gathered_bytes  <= gathered_bytes_next;
    end
  end

  assign push     = accept && (cmd.has_tail || cmd.err_count != 3'd0);
  assign push_cmd = cmd;

endmodule

// ===== src/utf8dec_queue.sv =====
module utf8dec_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  utf8dec_pkg::cmd_t push_cmd,
  output logic              not_full,
  input  logic              pop,
  output logic              head_valid,
  output utf8dec_pkg::cmd_t head_cmd
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  utf8dec_pkg::cmd_t  slots [Depth];
  logic [PtrW-1:0]    wr_ptr, rd_ptr;
  logic [CntW-1:0]    count;
  logic               do_push, do_pop;

  assign not_full   = (count != FullCnt);
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push && not_full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FullCnt)
    else $error("queue count beyond depth");

endmodule

// ===== src/utf8dec_back.sv =====
module utf8dec_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  utf8dec_pkg::cmd_t head_cmd,
  output logic              pop,
  utf8dec_char_if.source    char_stream
);

  logic [1:0]                    idx;
  logic [utf8dec_pkg::CNT_W-1:0] total;
  logic                          last;
  logic                          in_errors;
  logic                          load;

  logic                          out_valid;
  logic [utf8dec_pkg::CP_W-1:0]  out_cp;
  logic [utf8dec_pkg::CNT_W-1:0] out_count;
  logic                          out_bad;
  logic                          out_final;

  assign total     = head_cmd.err_count + {2'b00, head_cmd.has_tail};
  assign last      = ({1'b0, idx} == total - 3'd1);
  assign in_errors = ({1'b0, idx} < head_cmd.err_count);
  assign load      = head_valid && (!out_valid || char_stream.ready);
  assign pop       = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (!out_valid || char_stream.ready) begin
        out_valid <= head_valid;
      end
      if (load) begin
        idx <= last ? '0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_final <= head_cmd.eos && last;
      if (in_errors) begin
        out_cp    <= '0;
        out_count <= utf8dec_pkg::LEN_1;
        out_bad   <= 1'b1;
      end else begin
        out_cp    <= head_cmd.tail_bad ? '0 : head_cmd.tail_cp;
        out_count <= head_cmd.tail_count;
        out_bad   <= head_cmd.tail_bad;
      end
    end
  end

  assign char_stream.valid        = out_valid;
  assign char_stream.code_point   = out_cp;
  assign char_stream.byte_count   = out_count;
  assign char_stream.bad_sequence = out_bad;
  assign char_stream.final_result = out_final;

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_bad |-> out_cp == '0 && out_count == utf8dec_pkg::LEN_1)
    else $error("error result carries a value");

  a_scalar_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_bad |-> out_cp <= utf8dec_pkg::MAX_CP &&
      (out_cp < utf8dec_pkg::SURR_LO || out_cp > utf8dec_pkg::SURR_HI))
    else $error("decoded value is not a scalar value");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> {1'b0, idx} < total)
    else $error("result index past end of command");

endmodule

// ===== src/utf8_stream_decoder.sv =====
// Validating UTF-8 decoder. One byte is taken per cycle on byte_stream; each
// byte yields zero to four results on char_stream (a scalar value with its
// byte count, or one error per skipped byte, code point 0). Results leave at
// one per cycle from the output register while char_stream is ready. A command
// queue of QueueDepth entries sits between the byte classifier and the result
// sequencer, so the input keeps taking one byte per cycle as long as the output
// drains and error bursts fit in the queue; a byte that gives several results
// holds its queue entry until the last one is loaded into the output register.
// final_result marks the last result of a byte that carried end_of_string.
module utf8_stream_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic           clk,
  input  logic           rst,
  utf8dec_byte_if.sink   byte_stream,
  utf8dec_char_if.source char_stream
);

  logic              push, not_full, pop, head_valid;
  utf8dec_pkg::cmd_t push_cmd, head_cmd;

  utf8dec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .queue_ready (not_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  utf8dec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .not_full   (not_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  utf8dec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .char_stream (char_stream)
  );

endmodule

// ===== tb/sv/utf8_stream_decoder_tb.sv =====
module utf8_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD = 80;

  typedef struct packed {
    logic [utf8dec_pkg::CP_W-1:0]  code_point;
    logic [utf8dec_pkg::CNT_W-1:0] byte_count;
    logic                          bad_sequence;
    logic                          final_result;
  } char_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } byte_item_t;

  class utf8_scoreboard;
    logic [utf8dec_pkg::CP_W-1:0]  partial;
    logic [utf8dec_pkg::CNT_W-1:0] seq_len;
    logic [utf8dec_pkg::CNT_W-1:0] seq_taken;
    char_t                         step_q[$];
    char_t                         pending_chars[$];
    int unsigned                   mismatches;
    int unsigned                   bytes_taken;
    int unsigned                   chars_checked;
    int unsigned                   bad_checked;
    int unsigned                   strings_ended;

    function new();
      partial       = '0;
      seq_len       = utf8dec_pkg::LEN_NONE;
      seq_taken     = '0;
      mismatches    = 0;
      bytes_taken   = 0;
      chars_checked = 0;
      bad_checked   = 0;
      strings_ended = 0;
    endfunction

    function int unsigned outstanding();
      return pending_chars.size();
    endfunction

    function void add_char(logic [utf8dec_pkg::CP_W-1:0] cp,
                           logic [utf8dec_pkg::CNT_W-1:0] cnt, logic bad);
      if (step_q.size() < 4)
        step_q.push_back('{cp, cnt, bad, 1'b0});
    endfunction

    // skip-one-byte resync: every byte gathered so far turns into an error
    function void drop_sequence();
      for (int i = 0; i < seq_taken && i < 4; i++)
        add_char('0, utf8dec_pkg::LEN_1, 1'b1);
      partial   = '0;
      seq_len   = utf8dec_pkg::LEN_NONE;
      seq_taken = '0;
    endfunction

    function bit scalar_ok(logic [utf8dec_pkg::CP_W-1:0] v,
                           logic [utf8dec_pkg::CNT_W-1:0] len);
      logic [utf8dec_pkg::CP_W-1:0] min_cp;
      case (len)
        utf8dec_pkg::LEN_2: min_cp = utf8dec_pkg::MIN_CP_2;
        utf8dec_pkg::LEN_3: min_cp = utf8dec_pkg::MIN_CP_3;
        utf8dec_pkg::LEN_4: min_cp = utf8dec_pkg::MIN_CP_4;
        default:            min_cp = '0;
      endcase
      return v >= min_cp && v <= utf8dec_pkg::MAX_CP &&
             !(v >= utf8dec_pkg::SURR_LO && v <= utf8dec_pkg::SURR_HI);
    endfunction

    function utf8dec_pkg::byte_class_t sort_byte(logic [7:0] b);
      utf8dec_pkg::byte_class_t kind;
      casez (b)
        8'b0???????: kind = utf8dec_pkg::BC_ASCII;
        8'b10??????: kind = utf8dec_pkg::BC_CONT;
        8'b110?????: kind = utf8dec_pkg::BC_LEAD2;
        8'b1110????: kind = utf8dec_pkg::BC_LEAD3;
        8'b11110???: kind = utf8dec_pkg::BC_LEAD4;
        default:     kind = utf8dec_pkg::BC_BAD;
      endcase
      return kind;
    endfunction

    function void note_byte(logic [7:0] b, logic eos);
      utf8dec_pkg::byte_class_t kind;
      bit                       taken;
      kind  = sort_byte(b);
      taken = 0;
      step_q.delete();
      bytes_taken++;
      if (seq_len != utf8dec_pkg::LEN_NONE) begin
        if (kind == utf8dec_pkg::BC_CONT) begin
          partial   = {partial[utf8dec_pkg::CP_W-7:0], b[5:0]};
          seq_taken = seq_taken + 1'b1;
          taken     = 1;
          if (seq_taken >= seq_len) begin
            if (scalar_ok(partial, seq_len)) begin
              add_char(partial, seq_len, 1'b0);
              partial   = '0;
              seq_len   = utf8dec_pkg::LEN_NONE;
              seq_taken = '0;
            end else begin
              drop_sequence();
            end
          end
        end else begin
          drop_sequence();
        end
      end
      if (!taken) begin
        case (kind)
          utf8dec_pkg::BC_ASCII:
            add_char({{(utf8dec_pkg::CP_W-8){1'b0}}, b}, utf8dec_pkg::LEN_1, 1'b0);
          utf8dec_pkg::BC_LEAD2: begin
            seq_len   = utf8dec_pkg::LEN_2;
            partial   = {{(utf8dec_pkg::CP_W-5){1'b0}}, b[4:0]};
            seq_taken = utf8dec_pkg::LEN_1;
          end
          utf8dec_pkg::BC_LEAD3: begin
            seq_len   = utf8dec_pkg::LEN_3;
            partial   = {{(utf8dec_pkg::CP_W-4){1'b0}}, b[3:0]};
            seq_taken = utf8dec_pkg::LEN_1;
          end
          utf8dec_pkg::BC_LEAD4: begin
            seq_len   = utf8dec_pkg::LEN_4;
            partial   = {{(utf8dec_pkg::CP_W-3){1'b0}}, b[2:0]};
            seq_taken = utf8dec_pkg::LEN_1;
          end
          default: add_char('0, utf8dec_pkg::LEN_1, 1'b1);
        endcase
      end
      if (eos) begin
        strings_ended++;
        if (seq_len != utf8dec_pkg::LEN_NONE)
          drop_sequence();
        if (step_q.size() > 0)
          step_q[step_q.size()-1].final_result = 1'b1;
      end
      foreach (step_q[i])
        pending_chars.push_back(step_q[i]);
    endfunction

    function void check_char(char_t got);
      char_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected result: code_point=%0h byte_count=%0d %s=%0b final_result=%0b",
               got.code_point, got.byte_count, "bad_sequence", got.bad_sequence,
               got.final_result);
        mismatches++;
        return;
      end
      want = pending_chars.pop_front();
      chars_checked++;
      if (want.bad_sequence)
        bad_checked++;
      if (got.code_point !== want.code_point) begin
        $error("code_point: expected %0h, got %0h", want.code_point, got.code_point);
        mismatches++;
      end
      if (got.byte_count !== want.byte_count) begin
        $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
        mismatches++;
      end
      if (got.bad_sequence !== want.bad_sequence) begin
        $error("bad_sequence: expected %0b, got %0b", want.bad_sequence, got.bad_sequence);
        mismatches++;
      end
      if (got.final_result !== want.final_result) begin
        $error("final_result: expected %0b, got %0b", want.final_result, got.final_result);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  utf8dec_byte_if byte_if ();
  utf8dec_char_if char_if ();

  utf8_stream_decoder i_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_if),
    .char_stream (char_if)
  );

  utf8_scoreboard sb = new();

  byte_item_t  stim_q[$];
  bit          src_idle_en = 1'b1;
  bit          snk_idle_en = 1'b1;
  int unsigned rx_hold_left = 0;
  int unsigned cycle_count = 0;

  always #6 clk = ~clk;

  // both handshakes are sampled here, before any NBA of this edge lands
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_if.valid && byte_if.ready)
        sb.note_byte(byte_if.data_byte, byte_if.end_of_string);
      if (char_if.valid && char_if.ready)
        sb.check_char('{char_if.code_point, char_if.byte_count,
                        char_if.bad_sequence, char_if.final_result});
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Regression FAIL");
    $finish;
  end

  // result side backpressure, with an optional long hold-off
  initial begin
    char_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        char_if.ready <= 1'b0;
      end else if (snk_idle_en) begin
        char_if.ready <= ($urandom_range(99) >= 25);
      end else begin
        char_if.ready <= 1'b1;
      end
    end
  end

  function automatic void add_byte(logic [7:0] b, logic eos);
    stim_q.push_back('{b, eos});
  endfunction

  // push the first `keep` bytes of the len-byte form of cp
  function automatic void add_scalar(logic [20:0] cp, int len, int keep, logic eos);
    logic [7:0] enc[4];
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++)
      add_byte(enc[i], eos && (i == keep - 1));
  endfunction

  function automatic logic [20:0] legal_cp(int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp >= 'hD800 && cp <= 'hDFFF)
          cp = cp ^ 21'h2000;
      end
      default: cp = 21'($urandom_range('h1_0000, 'h10_FFFF));
    endcase
    return cp;
  endfunction

  // mostly well-formed sequences, the rest broken forms and noise
  function automatic void add_random_chunk();
    int   pick;
    int   len;
    int   n;
    logic eos;
    pick = $urandom_range(99);
    eos  = ($urandom_range(9) == 0);
    if (pick < 60) begin
      len = $urandom_range(1, 4);
      add_scalar(legal_cp(len), len, len, eos);
    end else if (pick < 68) begin
      len = $urandom_range(2, 4);
      case (len)
        2:       add_scalar(21'($urandom_range(0, 'h7F)), len, len, eos);
        3:       add_scalar(21'($urandom_range(0, 'h7FF)), len, len, eos);
        default: add_scalar(21'($urandom_range(0, 'hFFFF)), len, len, eos);
      endcase
    end else if (pick < 73) begin
      add_scalar(21'($urandom_range('hD800, 'hDFFF)), 3, 3, eos);
    end else if (pick < 78) begin
      add_scalar(21'($urandom_range('h11_0000, 'h1F_FFFF)), 4, 4, eos);
    end else if (pick < 88) begin
      len = $urandom_range(2, 4);
      add_scalar(legal_cp(len), len, $urandom_range(1, len - 1), eos);
    end else begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        add_byte(8'($urandom_range(0, 255)), eos && (i == n - 1));
    end
  endfunction

  task automatic send_byte(byte_item_t it);
    if (src_idle_en && $urandom_range(99) < 25) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    byte_if.valid         <= 1'b1;
    byte_if.data_byte     <= it.data_byte;
    byte_if.end_of_string <= it.end_of_string;
    @(posedge clk);
    while (!byte_if.ready)
      @(posedge clk);
  endtask

  task automatic send_queued();
    while (stim_q.size() > 0)
      send_byte(stim_q.pop_front());
  endtask

  task automatic send_random(int unsigned count);
    while (stim_q.size() < count)
      add_random_chunk();
    send_queued();
  endtask

  task automatic drain();
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    byte_if.valid         <= 1'b0;
    byte_if.data_byte     <= 8'h00;
    byte_if.end_of_string <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    add_byte(8'h00, 1'b0);                    // U+0000 is an ordinary char
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b0);                    // stray continuation
    add_byte(8'hFF, 1'b0);                    // illegal lead
    add_byte(8'hF8, 1'b0);
    add_scalar(21'h80, 2, 2, 1'b0);
    add_scalar(21'h00, 2, 2, 1'b0);           // overlong
    add_scalar(21'hD800, 3, 3, 1'b0);         // surrogate
    add_scalar(21'h11_0000, 4, 4, 1'b0);      // beyond U+10FFFF
    add_scalar(21'h10_FFFF, 4, 4, 1'b0);
    add_byte(8'hE0, 1'b0);                    // lead broken by ASCII
    add_byte(8'h41, 1'b0);
    add_scalar(21'h1_0000, 4, 2, 1'b1);       // truncated at end of string
    add_byte(8'h41, 1'b1);
    send_queued();

    send_random(100);

    // no idling on either side; receiver stalls long enough to back up the input
    src_idle_en  = 1'b0;
    snk_idle_en  = 1'b0;
    rx_hold_left = LONG_HOLD;
    send_random(95);
    drain();

    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    send_random(100);
    drain();

    $display("Decoded %0d bytes into %0d checked results (%0d error results, %0d strings)",
             sb.bytes_taken, sb.chars_checked, sb.bad_checked, sb.strings_ended);
    $display("Directed edge cases, random well-formed and broken sequences, long output stall");
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
